// File: sv/csi_escape_param_parser_macros.svh
// Assertion macros used by the checker file of the CSI parameter parser.
`ifndef CSI_ESCAPE_PARAM_PARSER_MACROS_SVH
`define CSI_ESCAPE_PARAM_PARSER_MACROS_SVH

// A general property, checked at each rising edge outside reset.
`define CEP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property failed");

// A valid that is not taken stays high into the next cycle.
`define CEP_ASSERT_HOLD(label, clk, rst, vld, rdy) \
   label: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy) |=> (vld))) \
      else $error("valid dropped before the beat was taken");

`endif

// File: sv/cep_pkg.sv
package cep_pkg;

   localparam int PARAM_SLOTS = 2;
   localparam int ADDR_W      = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;

   localparam logic [7:0]  BYTE_ESC      = 8'h1B;
   localparam logic [7:0]  BYTE_CSI      = 8'h9B;
   localparam logic [7:0]  BYTE_LBRACKET = 8'h5B;
   localparam logic [7:0]  BYTE_SEMI     = 8'h3B;
   localparam logic [7:0]  BYTE_ZERO     = 8'h30;
   localparam logic [7:0]  BYTE_NINE     = 8'h39;
   localparam logic [15:0] VALUE_MAX     = 16'hFFFF;
   localparam logic [3:0]  SLOT_MAX      = 4'd15;
   localparam logic [7:0]  COUNT_MAX     = 8'd255;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ESC,
      MODE_CSI
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DIGIT,
      OP_CLEAR,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic              vld;
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        digit;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [3:0] seen;
      logic [7:0] final_byte;
      logic [7:0] bytes_used;
   } info_type;

   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] slot;
      logic [15:0]       value;
      logic              last;
   } emit_type;

endpackage

// File: sv/cep_ctrl.sv
module cep_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_rx_byte,
   output logic              req_ready,
   input  logic              adv,
   input  logic              s1_emit,
   output cep_pkg::req_type  req,
   output cep_pkg::info_type info
);

   cep_pkg::mode_type             mode_ff, mode_in;
   logic [3:0]                    slot_ff, slot_in, slot_inc;
   logic [7:0]                    count_ff, count_in, count_inc;
   logic                          busy_ff, busy_in;
   logic [cep_pkg::ADDR_W-1:0]    k_ff, k_in;
   cep_pkg::info_type             info_ff, info_in;
   logic                          accept;
   logic                          is_digit;
   logic                          k_last;

   assign req_ready = !busy_ff && !s1_emit;
   assign accept    = req_valid && req_ready;
   assign info      = info_ff;
   assign slot_inc  = (slot_ff == cep_pkg::SLOT_MAX) ? slot_ff : slot_ff + 4'd1;
   assign count_inc = (count_ff == cep_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;
   assign is_digit  = (req_rx_byte >= cep_pkg::BYTE_ZERO) && (req_rx_byte <= cep_pkg::BYTE_NINE);
   assign k_last    = (k_ff == cep_pkg::ADDR_W'(cep_pkg::PARAM_SLOTS - 1));

   always_comb begin
      mode_in   = mode_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      k_in      = k_ff;
      info_in   = info_ff;
      req       = '0;
      req.op    = cep_pkg::OP_NONE;
      req.digit = 4'(req_rx_byte - cep_pkg::BYTE_ZERO);
      if (accept) begin
         count_in = count_inc;
         unique case (mode_ff)
            cep_pkg::MODE_ESC: begin
               mode_in = (req_rx_byte == cep_pkg::BYTE_LBRACKET) ? cep_pkg::MODE_CSI
                                                                 : cep_pkg::MODE_IDLE;
            end
            cep_pkg::MODE_CSI: begin
               if (is_digit) begin
                  if (slot_ff < 4'(cep_pkg::PARAM_SLOTS)) begin
                     req.vld  = 1'b1;
                     req.op   = cep_pkg::OP_DIGIT;
                     req.addr = slot_ff[cep_pkg::ADDR_W-1:0];
                  end
               end else if (req_rx_byte == cep_pkg::BYTE_SEMI) begin
                  slot_in = slot_inc;
                  if (slot_inc < 4'(cep_pkg::PARAM_SLOTS)) begin
                     req.vld  = 1'b1;
                     req.op   = cep_pkg::OP_CLEAR;
                     req.addr = slot_inc[cep_pkg::ADDR_W-1:0];
                  end
               end else begin
                  info_in.seen       = slot_inc;
                  info_in.final_byte = req_rx_byte;
                  info_in.bytes_used = count_inc;
                  busy_in            = 1'b1;
                  k_in               = '0;
                  mode_in            = cep_pkg::MODE_IDLE;
                  slot_in            = '0;
                  count_in           = '0;
               end
            end
            default: begin
               if (req_rx_byte == cep_pkg::BYTE_ESC) begin
                  mode_in = cep_pkg::MODE_ESC;
               end else if (req_rx_byte == cep_pkg::BYTE_CSI) begin
                  mode_in = cep_pkg::MODE_CSI;
               end else begin
                  mode_in = cep_pkg::MODE_IDLE;
               end
            end
         endcase
      end else if (busy_ff && adv) begin
         req.vld  = 1'b1;
         req.op   = cep_pkg::OP_EMIT;
         req.addr = k_ff;
         req.last = k_last;
         k_in     = k_ff + cep_pkg::ADDR_W'(1);
         if (k_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cep_pkg::MODE_IDLE;
         slot_ff  <= '0;
         count_ff <= '0;
         busy_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         mode_ff  <= mode_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
   end

endmodule

// File: sv/cep_store.sv
module cep_store (
   input  logic              clock,
   input  logic              reset,
   input  cep_pkg::req_type  req,
   input  logic              out_free,
   output logic              adv,
   output logic              s1_emit,
   output cep_pkg::emit_type emit
);

   logic [15:0]                  mem_ff [cep_pkg::PARAM_SLOTS];
   logic [15:0]                  rd_ff;
   cep_pkg::req_type             s1_ff;
   logic [cep_pkg::PARAM_SLOTS-1:0] vld_ff, vld_in;
   logic                         fwd_vld_ff;
   logic [cep_pkg::ADDR_W-1:0]   fwd_addr_ff;
   logic [15:0]                  fwd_data_ff;
   logic [15:0]                  cur;
   logic [19:0]                  sum;
   logic [15:0]                  sat;
   logic                         wr_en;

   // The forwarding register always holds the most recent write, so a hit on it
   // covers a read that was issued in the same cycle as that write.
   assign s1_emit = s1_ff.vld && (s1_ff.op == cep_pkg::OP_EMIT);
   assign adv     = !s1_emit || out_free;
   assign wr_en   = s1_ff.vld && (s1_ff.op == cep_pkg::OP_DIGIT);

   always_comb begin
      if (!vld_ff[s1_ff.addr]) begin
         cur = '0;
      end else if (fwd_vld_ff && (fwd_addr_ff == s1_ff.addr)) begin
         cur = fwd_data_ff;
      end else begin
         cur = rd_ff;
      end
      sum = 20'(cur) * 20'd10 + 20'(s1_ff.digit);
      sat = (sum > 20'(cep_pkg::VALUE_MAX)) ? cep_pkg::VALUE_MAX : sum[15:0];

      emit.vld   = s1_emit;
      emit.slot  = s1_ff.addr;
      emit.value = cur;
      emit.last  = s1_ff.last;

      vld_in = vld_ff;
      if (s1_ff.vld) begin
         case (s1_ff.op)
            cep_pkg::OP_DIGIT: vld_in[s1_ff.addr] = 1'b1;
            cep_pkg::OP_CLEAR: vld_in[s1_ff.addr] = 1'b0;
            cep_pkg::OP_EMIT: begin
               if (adv && s1_ff.last) begin
                  vld_in = '0;
               end
            end
            default: vld_in = vld_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv && req.vld) begin
         rd_ff <= mem_ff[req.addr];
      end
      if (wr_en) begin
         mem_ff[s1_ff.addr] <= sat;
         fwd_addr_ff        <= s1_ff.addr;
         fwd_data_ff        <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff      <= '0;
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_ff <= req;
         end
         vld_ff <= vld_in;
         if (wr_en) begin
            fwd_vld_ff <= 1'b1;
         end
      end
   end

endmodule

// File: sv/csi_escape_param_parser.sv
// Takes one byte per cycle while req_ready is high. A final byte blocks input
// while the parameter memory is read out on its single read port, one slot per cycle
// unless the result side stalls. The final byte sets the busy flag; each read request
// then passes the store stage register into the result register.
// Synchronous reset clears the parser and the per-slot valid bits at once; unwritten
// slots read as zero, so no clearing pass is needed.
module csi_escape_param_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_slot_index,
   output logic [15:0] rsp_param_value,
   output logic [3:0]  rsp_params_seen,
   output logic [7:0]  rsp_final_byte,
   output logic [7:0]  rsp_bytes_used,
   output logic        rsp_last_slot
);

   cep_pkg::req_type  req;
   cep_pkg::info_type info;
   cep_pkg::emit_type emit;
   logic              adv;
   logic              s1_emit;
   logic              out_free;
   logic              load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        slot_ff;
   logic [15:0]       value_ff;
   logic [3:0]        seen_ff;
   logic [7:0]        final_ff;
   logic [7:0]        used_ff;
   logic              last_ff;

   cep_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_ready   (req_ready),
      .adv         (adv),
      .s1_emit     (s1_emit),
      .req         (req),
      .info        (info)
   );

   cep_store u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .adv      (adv),
      .s1_emit  (s1_emit),
      .emit     (emit)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = emit.vld && adv;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff  <= 4'(emit.slot);
         value_ff <= emit.value;
         seen_ff  <= info.seen;
         final_ff <= info.final_byte;
         used_ff  <= info.bytes_used;
         last_ff  <= emit.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_param_value = value_ff;
   assign rsp_params_seen = seen_ff;
   assign rsp_final_byte  = final_ff;
   assign rsp_bytes_used  = used_ff;
   assign rsp_last_slot   = last_ff;

endmodule

// File: sv/cep_checker.sv
`include "csi_escape_param_parser_macros.svh"

module cep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_slot_index,
   input logic [15:0] rsp_param_value,
   input logic [3:0]  rsp_params_seen,
   input logic [7:0]  rsp_final_byte,
   input logic [7:0]  rsp_bytes_used,
   input logic        rsp_last_slot
);

   `CEP_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_ready)
   `CEP_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_param_value) && $stable(rsp_slot_index))
   `CEP_ASSERT(a_last_flag, clock, reset, rsp_valid |-> (rsp_last_slot == (rsp_slot_index == 4'(cep_pkg::PARAM_SLOTS - 1))))
   `CEP_ASSERT(a_next_slot, clock, reset, rsp_valid && rsp_ready && !rsp_last_slot |=> rsp_valid && (rsp_slot_index == $past(rsp_slot_index) + 4'd1))

endmodule

bind csi_escape_param_parser cep_checker u_cep_checker (.*);

// File: bench/tb_csi_escape_param_parser.sv
`timescale 1ns / 100ps

module tb_csi_escape_param_parser;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_BYTES  = 315;
   localparam int BURST_BYTES   = 100;

   typedef struct {
      logic [3:0]  slot_index;
      logic [15:0] param_value;
      logic [3:0]  params_seen;
      logic [7:0]  final_byte;
      logic [7:0]  bytes_used;
      logic        last_slot;
   } param_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_slot_index;
   logic [15:0] rsp_param_value;
   logic [3:0]  rsp_params_seen;
   logic [7:0]  rsp_final_byte;
   logic [7:0]  rsp_bytes_used;
   logic        rsp_last_slot;

   cep_pkg::mode_type parse_state;
   logic [3:0]        param_slot;
   logic [15:0]       param_acc [cep_pkg::PARAM_SLOTS];
   logic [7:0]        seq_bytes;

   param_beat_type pending_params [$];
   param_beat_type oldest_param;

   bit idling_on = 1'b1;
   int errors = 0;
   int cycles = 0;
   int bytes_sent = 0;
   int noise_bytes = 0;
   int beats_checked = 0;
   int sequences_closed = 0;
   int stall_left = 0;

   csi_escape_param_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_param_value (rsp_param_value),
      .rsp_params_seen (rsp_params_seen),
      .rsp_final_byte  (rsp_final_byte),
      .rsp_bytes_used  (rsp_bytes_used),
      .rsp_last_slot   (rsp_last_slot)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_parser();
      parse_state = cep_pkg::MODE_IDLE;
      param_slot  = '0;
      seq_bytes   = '0;
      for (int k = 0; k < cep_pkg::PARAM_SLOTS; k++) begin
         param_acc[k] = '0;
      end
   endfunction

   function automatic void advance_parser(input logic [7:0] b);
      logic [19:0] grown;
      param_beat_type beat;
      if (seq_bytes != cep_pkg::COUNT_MAX) begin
         seq_bytes++;
      end
      case (parse_state)
         cep_pkg::MODE_ESC: begin
            parse_state = (b == cep_pkg::BYTE_LBRACKET) ? cep_pkg::MODE_CSI
                                                        : cep_pkg::MODE_IDLE;
         end
         cep_pkg::MODE_CSI: begin
            if (b >= cep_pkg::BYTE_ZERO && b <= cep_pkg::BYTE_NINE) begin
               if (param_slot < cep_pkg::PARAM_SLOTS) begin
                  grown = 20'(param_acc[param_slot]) * 20'd10 + 20'(b - cep_pkg::BYTE_ZERO);
                  param_acc[param_slot] = (grown > 20'(cep_pkg::VALUE_MAX)) ?
                                          cep_pkg::VALUE_MAX : grown[15:0];
               end
            end else if (b == cep_pkg::BYTE_SEMI) begin
               if (param_slot != cep_pkg::SLOT_MAX) begin
                  param_slot++;
               end
               if (param_slot < cep_pkg::PARAM_SLOTS) begin
                  param_acc[param_slot] = '0;
               end
            end else begin
               for (int k = 0; k < cep_pkg::PARAM_SLOTS; k++) begin
                  beat.slot_index  = 4'(k);
                  beat.param_value = param_acc[k];
                  beat.params_seen = (param_slot == cep_pkg::SLOT_MAX) ? cep_pkg::SLOT_MAX
                                                                       : param_slot + 4'd1;
                  beat.final_byte  = b;
                  beat.bytes_used  = seq_bytes;
                  beat.last_slot   = (k == cep_pkg::PARAM_SLOTS - 1);
                  pending_params.push_back(beat);
               end
               sequences_closed++;
               clear_parser();
            end
         end
         default: begin
            if (b == cep_pkg::BYTE_ESC) begin
               parse_state = cep_pkg::MODE_ESC;
            end else if (b == cep_pkg::BYTE_CSI) begin
               parse_state = cep_pkg::MODE_CSI;
            end else begin
               parse_state = cep_pkg::MODE_IDLE;
            end
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function automatic logic [7:0] pick_final_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= cep_pkg::BYTE_ZERO && b <= cep_pkg::BYTE_NINE) ||
                 b == cep_pkg::BYTE_SEMI);
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      advance_parser(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_noise(input int count, input bit idle_only);
      logic [7:0] b;
      for (int n = 0; n < count; n++) begin
         do begin
            b = 8'($urandom_range(0, 255));
         end while (idle_only && (b == cep_pkg::BYTE_ESC || b == cep_pkg::BYTE_CSI));
         send_byte(b);
         noise_bytes++;
      end
   endtask

   task automatic send_random_sequence(input int max_params);
      int n_params;
      int n_digits;
      if ($urandom_range(0, 3) == 0) begin
         send_byte(cep_pkg::BYTE_CSI);
      end else begin
         send_byte(cep_pkg::BYTE_ESC);
         send_byte(cep_pkg::BYTE_LBRACKET);
      end
      n_params = $urandom_range(0, max_params);
      for (int p = 0; p < n_params; p++) begin
         if (p > 0) begin
            send_byte(cep_pkg::BYTE_SEMI);
         end
         n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
         for (int d = 0; d < n_digits; d++) begin
            send_byte(cep_pkg::BYTE_ZERO + 8'($urandom_range(0, 9)));
         end
      end
      send_byte(pick_final_byte());
   endtask

   task automatic test_basic_sequence();
      send_byte(cep_pkg::BYTE_ESC);
      send_byte(cep_pkg::BYTE_LBRACKET);
      send_byte("1");
      send_byte("2");
      send_byte(cep_pkg::BYTE_SEMI);
      send_byte("3");
      send_byte("4");
      send_byte("m");
      send_byte(cep_pkg::BYTE_CSI);
      send_byte(8'hFF);
   endtask

   task automatic test_after_escape();
      send_byte(cep_pkg::BYTE_ESC);
      send_byte(cep_pkg::BYTE_ESC);
      send_byte(cep_pkg::BYTE_ESC);
      send_byte(cep_pkg::BYTE_CSI);
      send_byte("x");
      send_byte(cep_pkg::BYTE_CSI);
      send_byte("5");
      send_byte("A");
   endtask

   task automatic test_value_saturation();
      send_byte(cep_pkg::BYTE_CSI);
      repeat (6) send_byte(cep_pkg::BYTE_NINE);
      send_byte(cep_pkg::BYTE_SEMI);
      send_byte(cep_pkg::BYTE_SEMI);
      send_byte("7");
      send_byte(8'h00);
   endtask

   task automatic test_counter_saturation();
      send_noise(260, 1'b1);
      send_byte(cep_pkg::BYTE_CSI);
      send_byte("0");
      send_byte("H");
      send_byte(cep_pkg::BYTE_ESC);
      send_byte(cep_pkg::BYTE_LBRACKET);
      send_byte("4");
      repeat (18) send_byte(cep_pkg::BYTE_SEMI);
      send_byte("8");
      send_byte("J");
   endtask

   task automatic test_random_traffic(input int target);
      int start;
      start = bytes_sent - noise_bytes;
      while (bytes_sent - noise_bytes - start < target) begin
         case ($urandom_range(0, 9))
            0: begin
               send_noise($urandom_range(1, 6), 1'b0);
            end
            1: begin
               send_byte(cep_pkg::BYTE_ESC);
               send_byte(($urandom_range(0, 1) == 0) ? cep_pkg::BYTE_ESC : pick_final_byte());
            end
            default: begin
               send_random_sequence(4);
            end
         endcase
      end
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      test_random_traffic(BURST_BYTES);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      clear_parser();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_sequence();
      test_after_escape();
      test_value_saturation();
      test_counter_saturation();
      test_random_traffic(RANDOM_BYTES);
      test_back_to_back();

      req_valid <= 1'b0;
      while (pending_params.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes (%0d of them line noise) and closed %0d CSI sequences.",
               bytes_sent, noise_bytes, sequences_closed);
      $display("Checked %0d parameter beats against the predicted parser state.",
               beats_checked);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_params.size() == 0) begin
            $error("unexpected beat: slot_index %0d param_value %0d",
                   rsp_slot_index, rsp_param_value);
            errors++;
         end else begin
            oldest_param = pending_params.pop_front();
            compare_field("slot_index", oldest_param.slot_index, rsp_slot_index);
            compare_field("param_value", oldest_param.param_value, rsp_param_value);
            compare_field("params_seen", oldest_param.params_seen, rsp_params_seen);
            compare_field("final_byte", oldest_param.final_byte, rsp_final_byte);
            compare_field("bytes_used", oldest_param.bytes_used, rsp_bytes_used);
            compare_field("last_slot", oldest_param.last_slot, rsp_last_slot);
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d beats outstanding.",
                  pending_params.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

// File: files.f
+incdir+sv
sv/cep_pkg.sv
sv/cep_ctrl.sv
sv/cep_store.sv
sv/csi_escape_param_parser.sv
sv/cep_checker.sv
bench/tb_csi_escape_param_parser.sv
